FILE: rtl/bme_pkg.sv
package bme_pkg;

  localparam int LEFT_MAX    = 16;
  localparam int RIGHT_MAX   = 16;
  localparam int LIDX_W      = $clog2(LEFT_MAX);
  localparam int RIDX_W      = $clog2(RIGHT_MAX);
  localparam int LCNT_W      = $clog2(LEFT_MAX + 1);
  localparam int RCNT_W      = $clog2(RIGHT_MAX + 1);
  localparam int STK_DEPTH   = RIGHT_MAX + 1;
  localparam int STK_IDX_W   = $clog2(STK_DEPTH);
  localparam int SP_W        = $clog2(STK_DEPTH + 1);
  localparam int REG_W       = 5;
  localparam int CFG_ADDR_W  = 1;
  localparam int ROW_VTX_W   = 4;
  localparam int ADJ_W       = 16;
  localparam int OUT_VTX_W   = 4;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_LEFT_VERTICES  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_VERTICES = 1'b1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_SOLVE = 1'b1;

  typedef struct packed {
    logic load_row;
    logic start_solve;
    logic start_root;
    logic scan_step;
    logic wb_step;
    logic emit_beat;
    logic emit_fail;
  } bme_cmd_t;

  typedef struct packed {
    logic found;
    logic free;
    logic sp_one;
    logic wb_done;
    logic root_last;
    logic emit_last;
    logic out_free;
  } bme_sts_t;

endpackage

FILE: rtl/bipartite_matching_engine.sv
// Kuhn augmenting-path bipartite matcher. A load beat (tuser 0) stores one
// adjacency row as it is accepted. A solve beat (tuser 1) clears the match
// table and, for each left vertex in order, runs a depth-first search on an
// explicit stack, one stack step per cycle (take the next unvisited neighbor,
// push its owner, or pop), then writes the found path back one frame per
// cycle. Each root takes a start step, one step per neighbor taken or frame
// popped, and one step per path frame written back. On success it sends one
// beat per left vertex with its right vertex, else one beat naming the first
// left vertex that could not be matched. Input is taken only when the engine
// is idle; the last output beat may still wait in the output register.
module bipartite_matching_engine import bme_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // row_vertex[3:0], adjacency_row[19:4], zero pad
  input  logic                  in_tuser,   // action[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // left_vertex[3:0], right_vertex[7:4]
  output logic                  out_tuser,  // matched[0]
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]      cfg_wdata
);

  bme_cmd_t             cmd;
  bme_sts_t             sts;
  logic [OUT_VTX_W-1:0] out_left;
  logic [OUT_VTX_W-1:0] out_right;

  bme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bme_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .row_vertex    (in_tdata[ROW_VTX_W-1:0]),
    .adjacency_row (in_tdata[ROW_VTX_W+ADJ_W-1:ROW_VTX_W]),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_matched   (out_tuser),
    .out_left      (out_left),
    .out_right     (out_right),
    .out_last      (out_tlast)
  );

  assign out_tdata = {out_right, out_left};

endmodule

FILE: rtl/bme_ctrl.sv
module bme_ctrl import bme_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_action,
  output logic     in_tready,
  input  bme_sts_t sts,
  output bme_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROOT = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_FAIL = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_action == ACT_SOLVE) begin
            cmd.start_solve = 1'b1;
            state_nxt       = S_ROOT;
          end else begin
            cmd.load_row = 1'b1;
          end
        end
      end
      S_ROOT: begin
        cmd.start_root = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.found) begin
          if (sts.free) state_nxt = S_WB;
        end else if (sts.sp_one) begin
          state_nxt = S_FAIL;
        end
      end
      S_WB: begin
        cmd.wb_step = 1'b1;
        if (sts.wb_done) state_nxt = sts.root_last ? S_EMIT : S_ROOT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_beat = 1'b1;
          if (sts.emit_last) state_nxt = S_IDLE;
        end
      end
      S_FAIL: begin
        if (sts.out_free) begin
          cmd.emit_fail = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: rtl/bme_dp.sv
module bme_dp import bme_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bme_cmd_t              cmd,
  output bme_sts_t              sts,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]      cfg_wdata,
  input  logic [ROW_VTX_W-1:0]  row_vertex,
  input  logic [ADJ_W-1:0]      adjacency_row,
  input  logic                  out_tready,
  output logic                  out_valid,
  output logic                  out_matched,
  output logic [OUT_VTX_W-1:0]  out_left,
  output logic [OUT_VTX_W-1:0]  out_right,
  output logic                  out_last
);

  logic [REG_W-1:0]     cfg_left_r;
  logic [REG_W-1:0]     cfg_right_r;
  logic [LCNT_W-1:0]    lc_r;
  logic [RCNT_W-1:0]    rc_r;
  logic [RIGHT_MAX-1:0] adj_r [LEFT_MAX];
  logic [LIDX_W-1:0]    own_u_r [RIGHT_MAX];
  logic [RIGHT_MAX-1:0] own_vld_r;
  logic [RIDX_W-1:0]    asg_r [LEFT_MAX];
  logic [RIGHT_MAX-1:0] visited_r;
  logic [LIDX_W-1:0]    stk_u_r [STK_DEPTH];
  logic [RIDX_W-1:0]    stk_cur_r [STK_DEPTH];
  logic [RCNT_W-1:0]    stk_next_r [STK_DEPTH];
  logic [SP_W-1:0]      sp_r;
  logic [STK_IDX_W-1:0] wb_i_r;
  logic [LIDX_W-1:0]    root_r;
  logic [LIDX_W-1:0]    emit_i_r;
  logic                 out_vld_r;
  logic                 out_matched_r;
  logic [OUT_VTX_W-1:0] out_left_r;
  logic [OUT_VTX_W-1:0] out_right_r;
  logic                 out_last_r;

  logic [STK_IDX_W-1:0] top_idx;
  logic [LIDX_W-1:0]    top_u;
  logic [RCNT_W-1:0]    top_next;
  logic [RIGHT_MAX-1:0] row;
  logic [RIGHT_MAX-1:0] cand;
  logic [RIDX_W-1:0]    v_sel;
  logic                 found;
  logic [LIDX_W-1:0]    wb_u;
  logic [RIDX_W-1:0]    wb_v;
  logic                 emit_last;
  logic                 root_last;
  logic                 wb_done;
  logic [LCNT_W-1:0]    lc_eff;
  logic [RCNT_W-1:0]    rc_eff;

  assign top_idx  = STK_IDX_W'(sp_r - SP_W'(1));
  assign top_u    = stk_u_r[top_idx];
  assign top_next = stk_next_r[top_idx];
  assign row      = adj_r[top_u];

  always_comb begin
    for (int v = 0; v < RIGHT_MAX; v++) begin
      cand[v] = row[v] & ~visited_r[v] & (RCNT_W'(v) < rc_r) & (RCNT_W'(v) >= top_next);
    end
    v_sel = '0;
    for (int v = RIGHT_MAX - 1; v >= 0; v--) begin
      if (cand[v]) v_sel = RIDX_W'(v);
    end
  end

  assign found     = |cand;
  assign wb_u      = stk_u_r[wb_i_r];
  assign wb_v      = stk_cur_r[wb_i_r];
  assign wb_done   = (SP_W'(wb_i_r) + SP_W'(1)) == sp_r;
  assign root_last = (LCNT_W'(root_r) + LCNT_W'(1)) == lc_r;
  assign emit_last = (LCNT_W'(emit_i_r) + LCNT_W'(1)) == lc_r;

  assign lc_eff = (cfg_left_r == '0) ? LCNT_W'(1) :
                  (32'(cfg_left_r) > LEFT_MAX) ? LCNT_W'(LEFT_MAX) : LCNT_W'(cfg_left_r);
  assign rc_eff = (cfg_right_r == '0) ? RCNT_W'(1) :
                  (32'(cfg_right_r) > RIGHT_MAX) ? RCNT_W'(RIGHT_MAX) : RCNT_W'(cfg_right_r);

  assign sts.found     = found;
  assign sts.free      = ~own_vld_r[v_sel];
  assign sts.sp_one    = (sp_r == SP_W'(1));
  assign sts.wb_done   = wb_done;
  assign sts.root_last = root_last;
  assign sts.emit_last = emit_last;
  assign sts.out_free  = ~out_vld_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_left_r  <= REG_W'(1);
      cfg_right_r <= REG_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LEFT_VERTICES:  cfg_left_r  <= cfg_wdata;
        REG_RIGHT_VERTICES: cfg_right_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_row && (32'(row_vertex) < LEFT_MAX)) begin
      adj_r[LIDX_W'(row_vertex)] <= RIGHT_MAX'(adjacency_row);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_vld_r <= '0;
      visited_r <= '0;
      sp_r      <= '0;
      lc_r      <= LCNT_W'(1);
      rc_r      <= RCNT_W'(1);
      root_r    <= '0;
      emit_i_r  <= '0;
      wb_i_r    <= '0;
    end else begin
      if (cmd.start_solve) begin
        own_vld_r <= '0;
        lc_r      <= lc_eff;
        rc_r      <= rc_eff;
        root_r    <= '0;
        emit_i_r  <= '0;
      end
      if (cmd.start_root) begin
        visited_r           <= '0;
        sp_r                <= SP_W'(1);
        stk_u_r[0]          <= root_r;
        stk_cur_r[0]        <= '0;
        stk_next_r[0]       <= '0;
      end
      if (cmd.scan_step) begin
        if (found) begin
          visited_r[v_sel]    <= 1'b1;
          stk_cur_r[top_idx]  <= v_sel;
          stk_next_r[top_idx] <= RCNT_W'(v_sel) + RCNT_W'(1);
          if (own_vld_r[v_sel]) begin
            stk_u_r[STK_IDX_W'(sp_r)]    <= own_u_r[v_sel];
            stk_cur_r[STK_IDX_W'(sp_r)]  <= '0;
            stk_next_r[STK_IDX_W'(sp_r)] <= '0;
            sp_r                         <= sp_r + SP_W'(1);
          end else begin
            wb_i_r <= '0;
          end
        end else begin
          sp_r <= sp_r - SP_W'(1);
        end
      end
      if (cmd.wb_step) begin
        own_u_r[wb_v]   <= wb_u;
        own_vld_r[wb_v] <= 1'b1;
        asg_r[wb_u]     <= wb_v;
        wb_i_r          <= wb_i_r + STK_IDX_W'(1);
        if (wb_done && !root_last) root_r <= root_r + LIDX_W'(1);
      end
      if (cmd.emit_beat) emit_i_r <= emit_i_r + LIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit_beat || cmd.emit_fail) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_beat) begin
      out_matched_r <= 1'b1;
      out_left_r    <= OUT_VTX_W'(emit_i_r);
      out_right_r   <= OUT_VTX_W'(asg_r[emit_i_r]);
      out_last_r    <= emit_last;
    end else if (cmd.emit_fail) begin
      out_matched_r <= 1'b0;
      out_left_r    <= OUT_VTX_W'(root_r);
      out_right_r   <= '0;
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_matched = out_matched_r;
  assign out_left    = out_left_r;
  assign out_right   = out_right_r;
  assign out_last    = out_last_r;

endmodule

FILE: tb/sv/bipartite_matching_engine_tb.sv
`timescale 1ns / 1ps

module bipartite_matching_engine_tb;
  import bme_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 32;
  localparam int SEGMENTS       = 8;
  localparam int SEG_ITEMS      = 44;

  typedef struct packed {
    logic                 matched;
    logic [OUT_VTX_W-1:0] left_v;
    logic [OUT_VTX_W-1:0] right_v;
    logic                 last;
  } match_beat_t;

  typedef enum logic [1:0] {STEP_BEAT, STEP_COUNTS} step_kind_t;

  typedef struct packed {
    step_kind_t           kind;
    logic                 act;
    logic [ROW_VTX_W-1:0] vtx;
    logic [ADJ_W-1:0]     adj;
    logic [REG_W-1:0]     lcnt;
    logic [REG_W-1:0]     rcnt;
    logic                 typed;
    match_beat_t          beat;
  } plan_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [REG_W-1:0]      cfg_wdata  = '0;

  bipartite_matching_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predictor state
  logic [ADJ_W-1:0]     adj_rows [LEFT_MAX];
  logic [REG_W-1:0]     left_cnt_reg  = 5'd1;
  logic [REG_W-1:0]     right_cnt_reg = 5'd1;
  int                   owner_of [RIGHT_MAX];
  bit                   owner_set [RIGHT_MAX];
  int                   match_of [LEFT_MAX];
  logic [RIGHT_MAX-1:0] seen_right;
  int                   stk_left [STK_DEPTH];
  int                   stk_right [STK_DEPTH];
  int                   stk_next [STK_DEPTH];

  match_beat_t match_exp_q [$];
  plan_row_t   plan_q [$];

  bit failed        = 1'b0;
  int gap_pct       = 0;
  int stall_pct     = 0;
  int send_calm     = 0;
  int recv_calm     = 0;
  int quiet_cycles  = 0;

  int gap_by_phase   [4]        = '{0, 46, 0, 19};
  int stall_by_phase [4]        = '{0, 0, 46, 19};
  logic [REG_W-1:0] seg_left  [SEGMENTS] = '{5'd16, 5'd0, 5'd31, 5'd5,
                                              5'd16, 5'd1, 5'd12, 5'd16};
  logic [REG_W-1:0] seg_right [SEGMENTS] = '{5'd16, 5'd31, 5'd0, 5'd16,
                                              5'd9, 5'd1, 5'd16, 5'd16};

  function automatic int clamp_count(logic [REG_W-1:0] v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Depth-first augmenting path from root over right vertices below rcount
  function automatic bit augment_path(int root, int rcount);
    int sp;
    int v;
    logic [ADJ_W-1:0] row;
    sp = 1;
    stk_left[0]  = root;
    stk_right[0] = 0;
    stk_next[0]  = 0;
    while (sp > 0) begin
      row = adj_rows[stk_left[sp-1]];
      v   = stk_next[sp-1];
      while (v < rcount && (!row[v] || seen_right[v])) v++;
      if (v >= rcount) begin
        sp--;
      end else begin
        seen_right[v]    = 1'b1;
        stk_right[sp-1]  = v;
        stk_next[sp-1]   = v + 1;
        if (!owner_set[v]) begin
          for (int i = 0; i < sp; i++) begin
            owner_of[stk_right[i]]  = stk_left[i];
            owner_set[stk_right[i]] = 1'b1;
            match_of[stk_left[i]]   = stk_right[i];
          end
          return 1'b1;
        end
        stk_left[sp]  = owner_of[v];
        stk_right[sp] = 0;
        stk_next[sp]  = 0;
        sp++;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_matching();
    int lc;
    int rc;
    int fail_at;
    match_beat_t b;
    lc = clamp_count(left_cnt_reg, LEFT_MAX);
    rc = clamp_count(right_cnt_reg, RIGHT_MAX);
    foreach (owner_of[i]) begin
      owner_of[i]  = 0;
      owner_set[i] = 1'b0;
    end
    foreach (match_of[i]) match_of[i] = 0;
    fail_at = -1;
    for (int u = 0; u < lc && fail_at < 0; u++) begin
      seen_right = '0;
      if (!augment_path(u, rc)) fail_at = u;
    end
    if (fail_at >= 0) begin
      b.matched = 1'b0;
      b.left_v  = fail_at[3:0];
      b.right_v = '0;
      b.last    = 1'b1;
      match_exp_q.insert(match_exp_q.size(), b);
    end else begin
      for (int u = 0; u < lc; u++) begin
        b.matched = 1'b1;
        b.left_v  = u[3:0];
        b.right_v = match_of[u][3:0];
        b.last    = (u == lc - 1);
        match_exp_q.insert(match_exp_q.size(), b);
      end
    end
  endfunction

  function automatic void step_load(logic [ROW_VTX_W-1:0] vtx, logic [ADJ_W-1:0] adj);
    plan_q.insert(plan_q.size(), {STEP_BEAT, ACT_LOAD, vtx, adj, 5'd0, 5'd0, 1'b0, 10'd0});
  endfunction

  function automatic void step_solve(logic typed, match_beat_t beat);
    plan_q.insert(plan_q.size(), {STEP_BEAT, ACT_SOLVE, 4'd0, 16'd0, 5'd0, 5'd0, typed, beat});
  endfunction

  function automatic void step_counts(logic [REG_W-1:0] l, logic [REG_W-1:0] r);
    plan_q.insert(plan_q.size(), {STEP_COUNTS, ACT_LOAD, 4'd0, 16'd0, l, r, 1'b0, 10'd0});
  endfunction

  function automatic void compare_field(string name, logic [3:0] expv, logic [3:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      failed = 1'b1;
    end
  endfunction

  task automatic send_item(logic act, logic [ROW_VTX_W-1:0] vtx, logic [ADJ_W-1:0] adj,
                           logic typed, match_beat_t beat);
    if (send_calm > 0) begin
      send_calm--;
    end else begin
      if ($urandom_range(15) == 0) send_calm = $urandom_range(24, 8);
      while ($urandom_range(99) < gap_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {4'b0, adj, vtx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (act == ACT_LOAD) adj_rows[vtx] = adj;
    else if (typed) match_exp_q.insert(match_exp_q.size(), beat);
    else predict_matching();
  endtask

  // Drop valid, wait for every expected beat, then let the engine go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (match_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_counts(logic [REG_W-1:0] l, logic [REG_W-1:0] r);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_LEFT_VERTICES;
    cfg_wdata <= l;
    @(posedge clk);
    cfg_addr  <= REG_RIGHT_VERTICES;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we        <= 1'b0;
    left_cnt_reg  = l;
    right_cnt_reg = r;
  endtask

  task automatic run_random(int quota);
    int sent;
    int lc;
    int rc;
    int pick;
    int n;
    int t;
    int perm [RIGHT_MAX];
    logic [ADJ_W-1:0] row;
    sent = 0;
    lc   = clamp_count(left_cnt_reg, LEFT_MAX);
    rc   = clamp_count(right_cnt_reg, RIGHT_MAX);
    while (sent < quota) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // graph built around a shuffled matching, sometimes with a hole
        for (int j = 0; j < rc; j++) perm[j] = j;
        for (int j = rc - 1; j > 0; j--) begin
          n       = $urandom_range(j);
          t       = perm[j];
          perm[j] = perm[n];
          perm[n] = t;
        end
        for (int j = 0; j < lc; j++) begin
          if ($urandom_range(3) == 0) row = 16'($urandom);
          else row = 16'($urandom & $urandom & $urandom);
          row[perm[j % rc]] = ($urandom_range(11) != 0);
          send_item(ACT_LOAD, j[3:0], row, 1'b0, '0);
        end
        send_item(ACT_SOLVE, 4'($urandom), 16'($urandom), 1'b0, '0);
        sent += lc + 1;
      end else if (pick < 85) begin
        n = $urandom_range(5, 1);
        for (int j = 0; j < n; j++) begin
          case ($urandom_range(3))
            0:       row = '0;
            1:       row = '1;
            default: row = 16'($urandom);
          endcase
          send_item(ACT_LOAD, 4'($urandom), row, 1'b0, '0);
        end
        send_item(ACT_SOLVE, 4'($urandom), 16'($urandom), 1'b0, '0);
        sent += n + 1;
      end else begin
        n = $urandom_range(3, 1);
        for (int j = 0; j < n; j++)
          send_item(ACT_LOAD, 4'($urandom), 16'($urandom), 1'b0, '0);
        sent += n;
      end
    end
  endtask

  always @(posedge clk) begin
    match_beat_t exp_beat;
    if (rst_n && out_tvalid && out_tready) begin
      if (match_exp_q.size() == 0) begin
        $error("unexpected result beat: tuser %0d tdata %h tlast %0d",
               out_tuser, out_tdata, out_tlast);
        failed = 1'b1;
      end else begin
        exp_beat = match_exp_q.pop_front();
        compare_field("matched", {3'b0, exp_beat.matched}, {3'b0, out_tuser});
        compare_field("left_vertex", exp_beat.left_v, out_tdata[3:0]);
        compare_field("right_vertex", exp_beat.right_v, out_tdata[7:4]);
        compare_field("last", {3'b0, exp_beat.last}, {3'b0, out_tlast});
      end
    end
    if (recv_calm > 0) begin
      recv_calm--;
      out_tready <= 1'b1;
    end else begin
      if ($urandom_range(31) == 0) recv_calm = $urandom_range(24, 8);
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    plan_row_t p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one left, one right vertex after reset
    step_load(4'd0, 16'h0001);
    step_solve(1'b1, {1'b1, 4'd0, 4'd0, 1'b1});
    // neighbors above the right count are ignored
    step_load(4'd0, 16'hFFFE);
    step_solve(1'b1, {1'b0, 4'd0, 4'd0, 1'b1});
    step_counts(5'd1, 5'd16);
    step_solve(1'b1, {1'b1, 4'd0, 4'd1, 1'b1});
    step_load(4'd0, 16'h8000);
    step_solve(1'b1, {1'b1, 4'd0, 4'd15, 1'b1});
    // zero counts saturate up to one
    step_counts(5'd0, 5'd0);
    step_solve(1'b1, {1'b0, 4'd0, 4'd0, 1'b1});
    // oversize counts saturate down to the maximum; chain forces deep searches
    step_counts(5'd31, 5'd31);
    step_load(4'd0, 16'h0001);
    for (int u = 1; u < LEFT_MAX; u++)
      step_load(u[3:0], (16'h0001 << u) | (16'h0001 << (u - 1)));
    step_solve(1'b0, '0);
    step_load(4'd7, 16'h0000);
    step_solve(1'b1, {1'b0, 4'd7, 4'd0, 1'b1});
    step_load(4'd7, 16'hFFFF);
    step_solve(1'b0, '0);

    foreach (plan_q[i]) begin
      p = plan_q[i];
      if (p.kind == STEP_COUNTS) begin
        settle();
        set_counts(p.lcnt, p.rcnt);
      end else begin
        send_item(p.act, p.vtx, p.adj, p.typed, p.beat);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      gap_pct   = gap_by_phase[seg / 2];
      stall_pct = stall_by_phase[seg / 2];
      set_counts(seg_left[seg], seg_right[seg]);
      run_random(SEG_ITEMS);
    end

    settle();
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
